// ===== rtl/core/rcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcfr_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int OUT_CHANNELS = 8;
	localparam int DATA_BYTES   = 2 * NUM_CHANNELS;
	// hunt, data bytes, two CRC bytes
	localparam int POS_W        = $clog2(DATA_BYTES + 3);

	localparam logic [7:0]  SYNC_BYTE = 8'hF6;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	localparam logic [1:0] ST_ACCEPT   = 2'd0;
	localparam logic [1:0] ST_ALL_ZERO = 2'd1;
	localparam logic [1:0] ST_CRC_BAD  = 2'd2;

	typedef logic [15:0] chan_t;

	typedef struct packed {
		logic [1:0]                     status;
		logic [OUT_CHANNELS-1:0][15:0]  chan;
	} result_t;

	// CRC-16/MCRF4XX, one byte, reflected form
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'h0};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcfr_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfr_deframer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       rx_byte,
	output logic                  last_byte,
	output rcfr_pkg::result_t     res
);
	import rcfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_low_q;
	chan_t            store_q [OUT_CHANNELS];

	logic [POS_W-1:0] d;
	logic [POS_W-1:0] ch;
	logic             hunting;
	logic             in_data;
	logic             crc_low_pos;
	logic             any_set;
	logic [15:0]      got;

	assign hunting     = (pos_q == '0);
	assign in_data     = !hunting && (pos_q <= POS_W'(DATA_BYTES));
	assign crc_low_pos = (pos_q == POS_W'(DATA_BYTES + 1));
	assign last_byte   = (pos_q == POS_W'(DATA_BYTES + 2));
	assign d           = pos_q - POS_W'(1);
	assign ch          = d >> 1;
	assign got         = {rx_byte, crc_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			crc_low_q <= '0;
		end else if (take) begin
			if (hunting) begin
				if (rx_byte == SYNC_BYTE) begin
					pos_q <= POS_W'(1);
					crc_q <= CRC_INIT;
				end
			end else if (in_data) begin
				crc_q <= crc_update(crc_q, rx_byte);
				pos_q <= pos_q + POS_W'(1);
			end else if (crc_low_pos) begin
				crc_low_q <= rx_byte;
				pos_q     <= pos_q + POS_W'(1);
			end else begin
				pos_q     <= '0;
				crc_q     <= CRC_INIT;
				crc_low_q <= '0;
			end
		end
	end

	// low byte clears the high half, high byte keeps the low half
	always_ff @(posedge clk) begin
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			if (take && in_data && (ch == POS_W'(i))) begin
				if (!d[0])
					store_q[i] <= {8'h00, rx_byte};
				else
					store_q[i][15:8] <= rx_byte;
			end
		end
	end

	always_comb begin
		any_set = 1'b0;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			if (i < NUM_CHANNELS)
				res.chan[i] = store_q[i];
			else
				res.chan[i] = '0;
			if (res.chan[i] != '0)
				any_set = 1'b1;
		end
		if (got != crc_q)
			res.status = ST_CRC_BAD;
		else if (!any_set)
			res.status = ST_ALL_ZERO;
		else
			res.status = ST_ACCEPT;
	end

endmodule

`default_nettype wire

// ===== rtl/core/rcfr_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire rcfr_pkg::result_t res_in,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output rcfr_pkg::result_t     res_out
);
	import rcfr_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc_frame_receiver_crc_check_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    rx_byte
// out      out_valid / out_ready  frame_status, chan_0 .. chan_7
//
// One byte per cycle. The frame result is registered and appears the cycle after
// the second CRC byte is taken. Bytes before the last of a frame are taken even while
// a result waits; the last byte waits until the result register is free or drained.
// Reset puts the receiver in sync hunt with the CRC at 0xFFFF; no clearing pass.

module rc_frame_receiver_crc_check_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       frame_status,
	output logic [15:0]      chan_0,
	output logic [15:0]      chan_1,
	output logic [15:0]      chan_2,
	output logic [15:0]      chan_3,
	output logic [15:0]      chan_4,
	output logic [15:0]      chan_5,
	output logic [15:0]      chan_6,
	output logic [15:0]      chan_7
);
	import rcfr_pkg::*;

	logic    take;
	logic    last_byte;
	result_t res_d;
	result_t res_q;

	assign in_ready = !last_byte || !out_valid || out_ready;
	assign take     = in_valid && in_ready;

	rcfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.res       (res_d)
	);

	rcfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && last_byte),
		.res_in    (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_out   (res_q)
	);

	assign frame_status = res_q.status;
	assign chan_0       = res_q.chan[0];
	assign chan_1       = res_q.chan[1];
	assign chan_2       = res_q.chan[2];
	assign chan_3       = res_q.chan[3];
	assign chan_4       = res_q.chan[4];
	assign chan_5       = res_q.chan[5];
	assign chan_6       = res_q.chan[6];
	assign chan_7       = res_q.chan[7];

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rcfr_pkg::*;

	localparam int HOLD_CYCLES  = 250;
	localparam int STALL_LIMIT  = 3000;
	localparam int RANDOM_WORDS = 1500;

	typedef logic [OUT_CHANNELS-1:0][15:0] chan_vec_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  frame_status;
	logic [15:0] chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6, chan_7;

	rc_frame_receiver_crc_check_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_status (frame_status),
		.chan_0       (chan_0),
		.chan_1       (chan_1),
		.chan_2       (chan_2),
		.chan_3       (chan_3),
		.chan_4       (chan_4),
		.chan_5       (chan_5),
		.chan_6       (chan_6),
		.chan_7       (chan_7)
	);

	// deframer state as seen by the predictor
	int          rx_pos;
	logic [15:0] rx_crc;
	chan_vec_t   rx_chans;
	logic [7:0]  rx_crc_lo;
	result_t     frames_due[$];

	int fail_count;
	int quiet_cycles;
	int frame_words;
	bit idle_on;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reflected CRC-16, poly 0x8408, one bit at a time
	function automatic logic [15:0] mcrf_crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
		return r;
	endfunction

	function automatic logic [15:0] payload_crc(input chan_vec_t v);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			c = mcrf_crc_step(c, v[i][7:0]);
			c = mcrf_crc_step(c, v[i][15:8]);
		end
		return c;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		int      idx;
		result_t want;
		if (rx_pos == 0) begin
			if (b == SYNC_BYTE) begin
				rx_pos = 1;
				rx_crc = CRC_INIT;
			end
		end else if (rx_pos <= DATA_BYTES) begin
			idx = (rx_pos - 1) >> 1;
			if (((rx_pos - 1) & 1) == 0)
				rx_chans[idx] = {8'h00, b};
			else
				rx_chans[idx][15:8] = b;
			rx_crc = mcrf_crc_step(rx_crc, b);
			rx_pos++;
		end else if (rx_pos == DATA_BYTES + 1) begin
			rx_crc_lo = b;
			rx_pos++;
		end else begin
			want.chan = rx_chans;
			if ({b, rx_crc_lo} != rx_crc)
				want.status = ST_CRC_BAD;
			else if (rx_chans == '0)
				want.status = ST_ALL_ZERO;
			else
				want.status = ST_ACCEPT;
			frames_due.push_back(want);
			rx_pos = 0;
			rx_crc = CRC_INIT;
			rx_crc_lo = 8'h00;
		end
	endfunction

	// entered and left at a falling edge; valid is left high for the caller
	task automatic push_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 11) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		@(negedge clk);
	endtask

	task automatic send_frame(input chan_vec_t v, input logic [15:0] crc_flip);
		logic [15:0] c;
		c = payload_crc(v) ^ crc_flip;
		push_byte(SYNC_BYTE);
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			push_byte(v[i][7:0]);
			push_byte(v[i][15:8]);
		end
		push_byte(c[7:0]);
		push_byte(c[15:8]);
		frame_words += DATA_BYTES + 3;
	endtask

	function automatic chan_vec_t random_chans();
		chan_vec_t v;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			case ($urandom_range(0, 7))
				0: v[i] = 16'h0000;
				1: v[i] = 16'hFFFF;
				2: v[i] = {SYNC_BYTE, SYNC_BYTE};
				default: v[i] = 16'($urandom);
			endcase
		end
		return v;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == SYNC_BYTE)
			b = ~b;
		return b;
	endfunction

	task automatic test_hunt_noise();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(SYNC_BYTE ^ 8'h01);
		push_byte(~SYNC_BYTE);
		push_byte(8'h5A);
	endtask

	task automatic test_all_zero_frame();
		send_frame('0, 16'h0000);
	endtask

	task automatic test_full_scale_frame();
		send_frame('1, 16'h0000);
	endtask

	task automatic test_crc_mismatch();
		send_frame(random_chans(), 16'h8001);
		send_frame('0, 16'hFFFF);
	endtask

	task automatic test_sync_in_payload();
		chan_vec_t v;
		for (int i = 0; i < OUT_CHANNELS; i++)
			v[i] = {SYNC_BYTE, SYNC_BYTE};
		send_frame(v, 16'h0000);
	endtask

	task automatic test_pause_until_drained();
		in_valid = 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
	endtask

	// receiver holds off; keep offering words until the block backs up
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		repeat (3) send_frame(random_chans(), 16'h0000);
		in_valid = 1'b0;
		while (hold_req) @(negedge clk);
	endtask

	task automatic test_random_traffic(input int n_words);
		int k;
		int start;
		start = frame_words;
		while (frame_words - start < n_words) begin
			case ($urandom_range(0, 19))
				0: begin
					// truncated frame, leaves the stream misaligned for a while
					k = $urandom_range(1, DATA_BYTES + 1);
					push_byte(SYNC_BYTE);
					repeat (k) push_byte(8'($urandom));
					frame_words += k + 1;
				end
				1, 2: begin
					k = $urandom_range(1, 4);
					repeat (k) push_byte(noise_byte());
					frame_words += k;
				end
				3: send_frame('0, ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom) | 16'h1);
				4, 5, 6: send_frame(random_chans(), 16'($urandom) | 16'h1);
				default: send_frame(random_chans(), 16'h0000);
			endcase
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (8) send_frame(random_chans(), ($urandom_range(0, 3) == 0) ? 16'h0100 : 16'h0000);
	endtask

	// receiver side: random stalls, or one long hold when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t   want;
		chan_vec_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {chan_7, chan_6, chan_5, chan_4, chan_3, chan_2, chan_1, chan_0};
			if (frames_due.size() == 0) begin
				$error("frame result with none expected: status %0d", frame_status);
				fail_count++;
			end else begin
				want = frames_due.pop_front();
				if (frame_status !== want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status, frame_status);
					fail_count++;
				end
				for (int i = 0; i < OUT_CHANNELS; i++) begin
					if (got[i] !== want.chan[i]) begin
						$error("chan_%0d: expected %h, got %h", i, want.chan[i], got[i]);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[rc_frame_receiver_crc_check_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		idle_on = 1'b1;
		hold_req = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		frame_words = 0;
		rx_pos = 0;
		rx_crc = CRC_INIT;
		rx_chans = '0;
		rx_crc_lo = 8'h00;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_hunt_noise();
		test_all_zero_frame();
		test_full_scale_frame();
		test_crc_mismatch();
		test_sync_in_payload();
		test_pause_until_drained();
		test_output_backpressure();
		test_random_traffic(RANDOM_WORDS);
		test_pause_until_drained();
		test_back_to_back();

		in_valid = 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[rc_frame_receiver_crc_check_top] OK");
		else
			$display("[rc_frame_receiver_crc_check_top] ERROR");
		$finish;
	end

endmodule
